// ----- rtl/core/cfws_pkg.sv -----
// Shared types and codes for the circular FIFO with search.
`default_nettype none

package cfws_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned CMP_W  = 8;

  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SRCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP = 2'd3;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_ENQ       = 3'd0,
    ST_OVF       = 3'd1,
    ST_DEQ       = 3'd2,
    ST_UNF       = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOTFOUND  = 3'd5,
    ST_DUMP      = 3'd6,
    ST_DUMPEMPTY = 3'd7
  } status_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/cfws_if.sv -----
// Command and result channel interfaces for the circular FIFO with search.
`default_nettype none

interface cfws_cmd_if;
  import cfws_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface cfws_res_if;
  import cfws_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic signed [DATA_W-1:0] data;
  logic                     last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cfws_mem.sv -----
// Ring storage: one write port, one read port with registered read data.
`default_nettype none

module cfws_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [AW-1:0]                     waddr,
  input  wire logic signed [cfws_pkg::DATA_W-1:0] wdata,
  input  wire logic                              re,
  input  wire logic [AW-1:0]                     raddr,
  output      logic signed [cfws_pkg::DATA_W-1:0] rdata
);
  import cfws_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read so a stalled consumer keeps its word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/core/cfws_ctrl.sv -----
// Command sequencer: pointers, occupancy, and the search and dump walks.
`default_nettype none

module cfws_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned PTR_W = 4,
  parameter int unsigned OCC_W = 5
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  cfws_cmd_if.sink                                in_chan,
  input  wire logic [cfws_pkg::CAP_W-1:0]         capacity,
  input  wire logic                               res_free,
  output      logic                               res_valid,
  output      cfws_pkg::res_t                     res,
  output      logic                               mem_we,
  output      logic [PTR_W-1:0]                   mem_waddr,
  output      logic signed [cfws_pkg::DATA_W-1:0] mem_wdata,
  output      logic                               mem_re,
  output      logic [PTR_W-1:0]                   mem_raddr,
  input  wire logic signed [cfws_pkg::DATA_W-1:0] mem_rdata
);
  import cfws_pkg::*;

  localparam int unsigned SUM_W = ((PTR_W > OCC_W) ? PTR_W : OCC_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEQ  = 4'b0010,
    S_SRCH = 4'b0100,
    S_DUMP = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [PTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [OCC_W-1:0]         occ_r, occ_nxt;
  logic [OCC_W-1:0]         idx_r, idx_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     full;
  logic                     hit;
  logic                     last_ent;
  logic [OCC_W-1:0]         idx_inc;

  // Ring position of an offset from the oldest entry; offset is at most DEPTH.
  function automatic logic [PTR_W-1:0] ring(input logic [PTR_W-1:0] ptr,
                                            input logic [OCC_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(ptr) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  assign full     = (CMP_W'(occ_r) >= CMP_W'(capacity)) || (occ_r == OCC_W'(DEPTH));
  assign hit      = (mem_rdata == val_r);
  assign idx_inc  = idx_r + OCC_W'(1);
  assign last_ent = (idx_inc == occ_r);

  always_comb begin
    state_nxt      = state_r;
    rd_ptr_nxt     = rd_ptr_r;
    occ_nxt        = occ_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    in_chan.ready  = 1'b0;
    res_valid      = 1'b0;
    res.status     = ST_ENQ;
    res.data       = in_chan.value;
    res.last       = 1'b1;
    mem_we         = 1'b0;
    mem_waddr      = ring(rd_ptr_r, occ_r);
    mem_wdata      = in_chan.value;
    mem_re         = 1'b0;
    mem_raddr      = rd_ptr_r;

    unique case (state_r)
      S_IDLE: begin
        in_chan.ready = res_free;
        if (in_chan.valid && res_free) begin
          val_nxt = in_chan.value;
          idx_nxt = '0;
          unique case (in_chan.cmd)
            CMD_ENQ: begin
              res_valid = 1'b1;
              if (full) begin
                res.status = ST_OVF;
              end else begin
                res.status = ST_ENQ;
                mem_we     = 1'b1;
                occ_nxt    = occ_r + OCC_W'(1);
              end
            end
            CMD_DEQ: begin
              if (occ_r == '0) begin
                res_valid  = 1'b1;
                res.status = ST_UNF;
                res.data   = '0;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_DEQ;
              end
            end
            CMD_SRCH: begin
              if (occ_r == '0) begin
                res_valid  = 1'b1;
                res.status = ST_NOTFOUND;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_SRCH;
              end
            end
            CMD_DUMP: begin
              if (occ_r == '0) begin
                res_valid  = 1'b1;
                res.status = ST_DUMPEMPTY;
                res.data   = '0;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_DUMP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_DEQ: begin
        if (res_free) begin
          res_valid  = 1'b1;
          res.status = ST_DEQ;
          res.data   = mem_rdata;
          rd_ptr_nxt = ring(rd_ptr_r, OCC_W'(1));
          occ_nxt    = occ_r - OCC_W'(1);
          state_nxt  = S_IDLE;
        end
      end
      S_SRCH: begin
        if (hit || last_ent) begin
          if (res_free) begin
            res_valid  = 1'b1;
            res.status = hit ? ST_FOUND : ST_NOTFOUND;
            res.data   = val_r;
            state_nxt  = S_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ring(rd_ptr_r, idx_inc);
          idx_nxt   = idx_inc;
        end
      end
      S_DUMP: begin
        if (res_free) begin
          res_valid  = 1'b1;
          res.status = ST_DUMP;
          res.data   = mem_rdata;
          res.last   = last_ent;
          if (last_ent) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ring(rd_ptr_r, idx_inc);
            idx_nxt   = idx_inc;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_ptr_r <= '0;
      occ_r    <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      occ_r    <= occ_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("memory read and write in the same cycle");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (idx_r < occ_r))
    else $error("walk offset past occupancy");

  a_dump_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP && res_valid && res.last) |=> (state_r == S_IDLE))
    else $error("dump did not end after its last beat");

endmodule

`default_nettype wire

// ----- rtl/core/circular_fifo_with_search.sv -----
// Top level of the circular FIFO with search: config register, storage, sequencer, output stage.
`default_nettype none

// Ring-buffer FIFO of signed 32-bit values. Each command beat on in_chan is
// an enqueue, dequeue, search or dump; results leave on out_chan, with last
// high on the final result beat of each command. The capacity written on
// cfg_we limits how many entries may be held (reset 16, values above DEPTH
// act as DEPTH, zero makes every enqueue overflow); write it only while the
// block is idle. Storage is one synchronous memory with a single read per
// cycle, and that read port sets the pace: enqueue and the empty cases
// answer from idle, dequeue reads the oldest entry first, search stops at
// the first match, and dump sends one entry beat per cycle while out_chan is
// ready. Commands are taken one at a time, and only when the result register
// is free or draining. Memory contents need no clearing after reset.
module circular_fifo_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [cfws_pkg::CAP_W-1:0]  cfg_wdata,
  cfws_cmd_if.sink                         in_chan,
  cfws_res_if.source                       out_chan
);
  import cfws_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);

  logic [CAP_W-1:0]         capacity_r;
  logic                     out_valid_r;
  res_t                     out_res_r;
  logic                     res_free;
  logic                     res_valid;
  res_t                     res;
  logic                     mem_we;
  logic [PTR_W-1:0]         mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [PTR_W-1:0]         mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  // Capacity register; no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  // The sequencer may hand over a beat when the output register is empty
  // or is being taken this cycle.
  assign res_free = !out_valid_r || out_chan.ready;

  cfws_mem #(
    .DEPTH (DEPTH),
    .AW    (PTR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cfws_ctrl #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W),
    .OCC_W (OCC_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .capacity  (capacity_r),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Output register: load on a free slot, hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.status = out_res_r.status;
  assign out_chan.data   = out_res_r.data;
  assign out_chan.last   = out_res_r.last;

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("result beat changed while stalled");

  a_no_res_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_free) |-> 1'b0)
    else $error("result offered without a free output slot");

  a_accept_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |-> res_free)
    else $error("command taken with output slot busy");

endmodule

`default_nettype wire

// ----- test/cfws_scoreboard.sv -----
// Scoreboard for the circular FIFO with search: shadow ring, expected beats, field compare.
`timescale 1ns / 100ps

module cfws_scoreboard #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cfws_pkg::CAP_W-1:0]   cfg_wdata,
  cfws_cmd_if                          cmd_mon,
  cfws_res_if                          res_mon,
  output int unsigned                  mismatches,
  output int unsigned                  results_owed
);
  import cfws_pkg::*;

  logic signed [DATA_W-1:0] shadow_ring [DEPTH];
  int unsigned              oldest;
  int unsigned              held;
  logic [CAP_W-1:0]         capacity;
  res_t                     owed_results [$];
  int unsigned              bad_fields;

  function automatic void owe(status_t st, logic signed [DATA_W-1:0] d, logic lst);
    res_t r;
    r.status = st;
    r.data   = d;
    r.last   = lst;
    owed_results.push_back(r);
  endfunction

  // Work out the result beats of one accepted command and advance the shadow ring.
  function automatic void predict_fifo_response(logic [CMD_W-1:0] op,
                                                logic signed [DATA_W-1:0] v);
    int unsigned room;
    bit          hit;
    room = (capacity > DEPTH) ? DEPTH : capacity;
    hit  = 1'b0;
    case (op)
      CMD_ENQ: begin
        if (held >= room) begin
          owe(ST_OVF, v, 1'b1);
        end else begin
          shadow_ring[(oldest + held) % DEPTH] = v;
          held++;
          owe(ST_ENQ, v, 1'b1);
        end
      end
      CMD_DEQ: begin
        if (held == 0) begin
          owe(ST_UNF, '0, 1'b1);
        end else begin
          owe(ST_DEQ, shadow_ring[oldest], 1'b1);
          oldest = (oldest + 1) % DEPTH;
          held--;
        end
      end
      CMD_SRCH: begin
        for (int unsigned i = 0; i < held; i++)
          if (shadow_ring[(oldest + i) % DEPTH] == v) hit = 1'b1;
        owe(hit ? ST_FOUND : ST_NOTFOUND, v, 1'b1);
      end
      default: begin
        if (held == 0) begin
          owe(ST_DUMPEMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < held; i++)
            owe(ST_DUMP, shadow_ring[(oldest + i) % DEPTH], i + 1 == held);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      oldest     = 0;
      held       = 0;
      capacity   = CAP_RESET;
      bad_fields = 0;
      owed_results.delete();
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      // Push before pop so a same-edge result still lines up with the oldest command.
      if (cmd_mon.valid && cmd_mon.ready) predict_fifo_response(cmd_mon.cmd, cmd_mon.value);
      if (res_mon.valid && res_mon.ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result beat: status %0d data %0d last %0d",
                 res_mon.status, res_mon.data, res_mon.last);
          bad_fields++;
        end else begin
          want = owed_results.pop_front();
          if (res_mon.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, res_mon.status);
            bad_fields++;
          end
          if (res_mon.data !== want.data) begin
            $error("data: expected %0d actual %0d", want.data, res_mon.data);
            bad_fields++;
          end
          if (res_mon.last !== want.last) begin
            $error("last: expected %0d actual %0d", want.last, res_mon.last);
            bad_fields++;
          end
        end
      end
    end
    mismatches   <= bad_fields;
    results_owed <= owed_results.size();
  end

endmodule

// ----- test/circular_fifo_with_search_test.sv -----
// Testbench top for the circular FIFO with search: clock, reset, commands, result stalls, verdict.
`timescale 1ns / 100ps

module circular_fifo_with_search_test;
  import cfws_pkg::*;

  localparam int unsigned DEPTH       = 16;
  // Watchdog limit; leaves ample headroom over the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CAP_W-1:0]         cfg_wdata;
  int unsigned              mismatches;
  int unsigned              results_owed;
  int unsigned              cycle_count = 0;
  int unsigned              send_burst = 0;
  int unsigned              take_burst = 0;
  logic signed [DATA_W-1:0] recent_values [8] = '{default: '0};
  int unsigned              recent_slot = 0;

  cfws_cmd_if in_chan();
  cfws_res_if out_chan();

  circular_fifo_with_search #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  cfws_scoreboard #(.DEPTH(DEPTH)) scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd_mon      (in_chan),
    .res_mon      (out_chan),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Draw the idle gap before a beat: mostly uniform at random, with bursts of back-to-back beats.
  function automatic int unsigned draw_gap(ref int unsigned burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // Pick an operand: extremes, repeats of recently enqueued values (search hits,
  // duplicates), or a fully random word.
  function automatic logic signed [DATA_W-1:0] draw_value();
    case ($urandom_range(0, 5))
      0, 1: return recent_values[$urandom_range(0, 7)];
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Present one command beat and hold it until the block takes it.
  task automatic send_command(input logic [CMD_W-1:0] op, input logic signed [DATA_W-1:0] v);
    int unsigned gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.cmd   <= op;
    in_chan.value <= v;
    if (op == CMD_ENQ) begin
      recent_values[recent_slot] = v;
      recent_slot = (recent_slot + 1) % 8;
    end
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Drain the block, then write the capacity register while nothing is in flight.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random stretch at a fixed capacity. fill_pct steers toward full or empty;
  // the rest splits between dequeue, search and dump.
  task automatic random_phase(input logic [CAP_W-1:0] cap, input int unsigned fill_pct,
                              input int unsigned count);
    int unsigned roll;
    int unsigned deq_top;
    int unsigned srch_top;
    deq_top  = fill_pct + (100 - fill_pct) / 2;
    srch_top = deq_top + (100 - fill_pct) / 3;
    write_capacity(cap);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < fill_pct)
        send_command(CMD_ENQ, draw_value());
      else if (roll < deq_top)
        send_command(CMD_DEQ, $urandom());
      else if (roll < srch_top)
        send_command(CMD_SRCH, draw_value());
      else
        send_command(CMD_DUMP, $urandom());
    end
  endtask

  // Result side: stall ready per beat, with stretches of no stall at all.
  initial begin
    int unsigned stall;
    out_chan.ready = 1'b0;
    forever begin
      stall = draw_gap(take_burst);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_chan.valid = 1'b0;
    in_chan.cmd   = CMD_ENQ;
    in_chan.value = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty FIFO at reset capacity: underflow, dump-empty, search miss.
    send_command(CMD_DEQ, 32'sd0);
    send_command(CMD_DUMP, 32'sd0);
    send_command(CMD_SRCH, 32'sd5);
    // Extreme values in, then hit, miss, multi-beat dump, dequeue of the oldest.
    send_command(CMD_ENQ, 32'sh8000_0000);
    send_command(CMD_ENQ, 32'sh7fff_ffff);
    send_command(CMD_ENQ, 32'sh0000_0000);
    send_command(CMD_ENQ, -32'sd1);
    send_command(CMD_SRCH, 32'sh7fff_ffff);
    send_command(CMD_SRCH, 32'sd1);
    send_command(CMD_DUMP, 32'sd0);
    send_command(CMD_DEQ, 32'sd0);

    // Capacity lowered below occupancy: entries stay, enqueue overflows until drained.
    write_capacity(5'd1);
    send_command(CMD_ENQ, 32'sd7);
    send_command(CMD_DEQ, 32'sd0);
    send_command(CMD_DEQ, 32'sd0);
    send_command(CMD_ENQ, 32'sd8);
    send_command(CMD_DEQ, 32'sd0);
    send_command(CMD_ENQ, 32'sd9);

    // Capacity zero: every enqueue overflows; a one-entry dump carries last.
    write_capacity(5'd0);
    send_command(CMD_ENQ, 32'sd10);
    send_command(CMD_DUMP, 32'sd0);
    send_command(CMD_DEQ, 32'sd0);
    send_command(CMD_DEQ, 32'sd0);

    // Random stretches; capacity 31 acts as DEPTH, enqueue-heavy mixes reach full and wrap.
    random_phase(5'd31, 75, 20);
    random_phase(5'd16, 45, 20);
    random_phase(5'd0, 20, 10);
    random_phase(CAP_W'($urandom_range(2, 15)), 60, 20);
    random_phase(5'd1, 50, 10);
    random_phase(CAP_RESET, 55, 20);

    // Drop valid, drain every owed beat, then allow a dump's worth of quiet cycles.
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
